// ===== design/mhd_pkg.sv =====
// Package for the motion hysteresis detector: word layouts, register indexes,
// register reset values and result transition codes.
// No dependencies; imported by the top level and by its checker.
package mhd_pkg;

  // Field widths of one input word and one result word.
  localparam int unsigned RatioW  = 14;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned RunW    = 4;
  localparam int unsigned PeriodW = 16;

  // Packed stream widths, rounded up to whole bytes.
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 8;

  // Configuration port widths.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_TRIGGER_LEVEL   = 2'd0,
    REG_RELEASE_LEVEL   = 2'd1,
    REG_CONFIRM_COUNT   = 2'd2,
    REG_QUIET_PERIOD_MS = 2'd3
  } reg_idx_e;

  // Register values after reset.
  localparam logic [RatioW-1:0]  TriggerReset = 14'd300;
  localparam logic [RatioW-1:0]  ReleaseReset = 14'd20;
  localparam logic [RunW-1:0]    ConfirmReset = 4'd3;
  localparam logic [PeriodW-1:0] PeriodReset  = 16'd2000;

  // Strong-run saturation point and the level that enables the half test.
  localparam logic [RunW-1:0]   RunMax       = 4'd15;
  localparam logic [LevelW-1:0] HalfTestLvl  = 8'd2;

  // Transition code of a result word.
  typedef enum logic [1:0] {
    TR_NONE = 2'd0,
    TR_ON   = 2'd1,
    TR_OFF  = 2'd2
  } transition_e;

endpackage

// ===== design/motion_hysteresis_detector.sv =====
// Motion hysteresis detector: strong-sample confirm counter to switch on,
// wrap-safe quiet hold timer to switch off. Depends on mhd_pkg.
//
//   channel  | direction | handshake              | word
//   ---------+-----------+------------------------+-----------------------------------
//   s_axis   | in        | s_axis_tvalid/tready   | ratio, moving level, time in ms
//   m_axis   | out       | m_axis_tvalid/tready   | motion_active, transition
//   cfg      | in        | cfg_valid_i/cfg_ready_o| register index, write data
//
// One sample word is accepted per cycle while s_axis_tready is high. A word goes
// into an input register, is evaluated against the detector state and lands in
// the result register, from which it is offered on m_axis. The limit of one word
// per cycle is set by the state update, which reads the state written by the word
// before. Reset (rst_ni low) clears both registers' valid flags, the detector state
// and loads the register reset values. While the result register is stalled, the
// input register still takes one word; s_axis_tready only drops when both are full.
module motion_hysteresis_detector #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Sample stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [13:0] ratio_hundredths, [21:14] motion_level, [53:22] time_ms, [55:54] zero
  input  logic [mhd_pkg::InDataW-1:0]      s_axis_tdata,
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] motion_active, [2:1] transition, [7:3] zero
  output logic [mhd_pkg::OutDataW-1:0]     m_axis_tdata,
  // Configuration writes.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mhd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [mhd_pkg::CfgDataW-1:0]     cfg_data_i
);
  import mhd_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers; writes are always taken. Software must write only
  // while idle: the block does not enforce this and has no datapath interlock.
  // ---------------------------------------------------------------------------
  logic [RatioW-1:0]  trigger_q;
  logic [RatioW-1:0]  release_q;
  logic [RunW-1:0]    confirm_q;
  logic [PeriodW-1:0] period_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_q <= TriggerReset;
      release_q <= ReleaseReset;
      confirm_q <= ConfirmReset;
      period_q  <= PeriodReset;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_TRIGGER_LEVEL:   trigger_q <= cfg_data_i[RatioW-1:0];
        REG_RELEASE_LEVEL:   release_q <= cfg_data_i[RatioW-1:0];
        REG_CONFIRM_COUNT:   confirm_q <= cfg_data_i[RunW-1:0];
        REG_QUIET_PERIOD_MS: period_q  <= cfg_data_i[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register.
  // ---------------------------------------------------------------------------
  logic                 in_vld_q;
  logic [RatioW-1:0]    ratio_q;
  logic [LevelW-1:0]    level_q;
  logic [TimeW-1:0]     time_q;
  logic                 out_vld_q;
  logic                 advance;

  // The input register moves on whenever the result register is free or
  // being emptied in this cycle.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      ratio_q <= s_axis_tdata[RatioW-1:0];
      level_q <= s_axis_tdata[RatioW+LevelW-1:RatioW];
      time_q  <= s_axis_tdata[RatioW+LevelW+TimeW-1:RatioW+LevelW];
    end
  end

  // ---------------------------------------------------------------------------
  // Detector state and next-state logic.
  // ---------------------------------------------------------------------------
  logic                 active_q,  active_d;
  logic [RunW-1:0]      run_q,     run_d;
  logic                 quiet_q,   quiet_d;
  logic [TIME_BITS-1:0] start_q,   start_d;
  transition_e          trans_d;

  logic                 strong_smp;
  logic                 quiet_smp;
  logic [RunW-1:0]      run_inc;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] elapsed;

  // Sample time taken modulo 2^TIME_BITS.
  assign now = TIME_BITS'(time_q);

  // Strong when the ratio reaches the trigger, or when there is real movement
  // and twice the ratio reaches it.
  assign strong_smp = (ratio_q >= trigger_q) ||
                      ((level_q >= HalfTestLvl) && ({ratio_q, 1'b0} >= {1'b0, trigger_q}));

  assign quiet_smp = (level_q == '0) && (ratio_q <= release_q);

  always_comb begin
    active_d = active_q;
    run_d    = run_q;
    quiet_d  = quiet_q;
    start_d  = start_q;
    trans_d  = TR_NONE;
    run_inc  = (run_q == RunMax) ? run_q : run_q + 1'b1;
    elapsed  = '0;

    if (!active_q) begin
      run_d = strong_smp ? run_inc : '0;
      if (run_d >= confirm_q) begin
        active_d = 1'b1;
        run_d    = '0;
        quiet_d  = 1'b0;
        trans_d  = TR_ON;
      end
    end else if (quiet_smp) begin
      // The first quiet sample starts the hold timer at its own time.
      if (!quiet_q) begin
        quiet_d = 1'b1;
        start_d = now;
      end
      elapsed = now - start_d;
      if (elapsed >= TIME_BITS'(period_q)) begin
        active_d = 1'b0;
        quiet_d  = 1'b0;
        run_d    = '0;
        trans_d  = TR_OFF;
      end
    end else begin
      quiet_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      run_q    <= '0;
      quiet_q  <= 1'b0;
      start_q  <= '0;
    end else if (advance) begin
      active_q <= active_d;
      run_q    <= run_d;
      quiet_q  <= quiet_d;
      start_q  <= start_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  logic        res_active_q;
  transition_e res_trans_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_active_q <= active_d;
      res_trans_q  <= trans_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW-3){1'b0}}, res_trans_q, res_active_q};

endmodule

// ===== design/mhd_checker.sv =====
// Port-level checker for the motion hysteresis detector, attached by bind.
// Depends on mhd_pkg and on the port list of motion_hysteresis_detector.
module mhd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [mhd_pkg::OutDataW-1:0]     m_axis_tdata
);
  import mhd_pkg::*;

  // A result word waiting on the sink holds still until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result word changed while stalled");

  // No result word is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // The sample side only stalls when the result side is full and stalled.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // A switch-on word reports motion active and a switch-off word reports it idle.
  a_trans_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tdata[2:1] == TR_ON && m_axis_tdata[0]) ||
       (m_axis_tdata[2:1] == TR_OFF && !m_axis_tdata[0]) ||
       (m_axis_tdata[2:1] == TR_NONE)))
    else $error("transition code disagrees with motion state");

endmodule

bind motion_hysteresis_detector mhd_checker u_mhd_checker (.*);

// ===== dv/motion_hysteresis_detector_test.sv =====
// Self-checking test of motion_hysteresis_detector: directed and random sample words,
// predicted results checked in order on the result stream.
// Depends on mhd_pkg and the motion_hysteresis_detector RTL.
module motion_hysteresis_detector_test;
  import mhd_pkg::*;

  localparam int unsigned RatioMaxVal   = (1 << RatioW) - 1;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned WordsPerPhase = 130;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned SettleCycles  = 16;
  localparam int unsigned MaxReports    = 10;

  typedef struct packed {
    logic [RatioW-1:0] ratio;
    logic [LevelW-1:0] level;
    logic [TimeW-1:0]  time_ms;
  } motion_sample_t;

  typedef struct packed {
    logic        active;
    transition_e transition;
  } motion_result_t;

  typedef enum int {
    KIND_STRONG,
    KIND_WEAK,
    KIND_QUIET,
    KIND_BUSY,
    KIND_NOISE
  } sample_kind_e;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                s_axis_tvalid  = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata   = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready  = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  reg_idx_e            cfg_index_i    = REG_TRIGGER_LEVEL;
  logic [CfgDataW-1:0] cfg_data_i     = '0;

  // Shadow copy of the detector registers and state.
  logic [RatioW-1:0]  trigger_lvl  = TriggerReset;
  logic [RatioW-1:0]  release_lvl  = ReleaseReset;
  logic [RunW-1:0]    confirm_cnt  = ConfirmReset;
  logic [PeriodW-1:0] quiet_per    = PeriodReset;
  logic               det_active   = 1'b0;
  logic [RunW-1:0]    strong_run   = '0;
  logic               quiet_timing = 1'b0;
  logic [TimeW-1:0]   quiet_start  = '0;

  motion_result_t results_due[$];
  logic [TimeW-1:0] now_ms = '0;
  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct  = 0;
  int unsigned fault_count     = 0;
  int unsigned cycle_count     = 0;

  motion_hysteresis_detector #(
    .TIME_BITS(TimeW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The result side stalls at random with the rate of the current phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic note_fault(input string what);
    fault_count++;
    if (fault_count <= MaxReports) begin
      $display("[%0d] mismatch: %s", cycle_count, what);
    end
  endtask

  // Updates the shadow state for one sample word and returns the result it causes.
  function automatic motion_result_t advance_detector(input motion_sample_t smp);
    motion_result_t   res;
    logic [RatioW:0]  twice_ratio;
    logic [TimeW-1:0] elapsed;
    logic             strong_smp;
    logic             quiet;
    res.transition = TR_NONE;
    twice_ratio = {smp.ratio, 1'b0};
    if (!det_active) begin
      strong_smp = (smp.ratio >= trigger_lvl) ||
                   (smp.level >= HalfTestLvl && twice_ratio >= {1'b0, trigger_lvl});
      if (!strong_smp) begin
        strong_run = '0;
      end else if (strong_run != RunMax) begin
        strong_run = strong_run + 1'b1;
      end
      if (strong_run >= confirm_cnt) begin
        det_active   = 1'b1;
        strong_run   = '0;
        quiet_timing = 1'b0;
        res.transition = TR_ON;
      end
    end else begin
      quiet = (smp.level == '0) && (smp.ratio <= release_lvl);
      if (quiet) begin
        if (!quiet_timing) begin
          quiet_timing = 1'b1;
          quiet_start  = smp.time_ms;
        end
        elapsed = smp.time_ms - quiet_start;
        if (elapsed >= TimeW'(quiet_per)) begin
          det_active   = 1'b0;
          quiet_timing = 1'b0;
          strong_run   = '0;
          res.transition = TR_OFF;
        end
      end else begin
        quiet_timing = 1'b0;
      end
    end
    res.active = det_active;
    return res;
  endfunction

  function automatic motion_sample_t motion_sample(input int unsigned ratio,
                                                   input int unsigned level,
                                                   input logic [TimeW-1:0] stamp);
    motion_sample_t smp;
    smp.ratio   = RatioW'(ratio);
    smp.level   = LevelW'(level);
    smp.time_ms = stamp;
    return smp;
  endfunction

  // Picks a sample that steers the detector through its states: mostly strong
  // words while idle and mostly quiet words while active, with noise mixed in.
  function automatic motion_sample_t draw_sample();
    motion_sample_t smp;
    sample_kind_e   kind;
    int unsigned    roll;
    int unsigned    trig;
    int unsigned    rel;
    roll = $urandom_range(99);
    trig = 32'(trigger_lvl);
    rel  = 32'(release_lvl);
    if (!det_active) begin
      kind = (roll < 75) ? KIND_STRONG : (roll < 90) ? KIND_WEAK : KIND_NOISE;
    end else begin
      kind = (roll < 70) ? KIND_QUIET : (roll < 90) ? KIND_BUSY : KIND_NOISE;
    end
    if ($urandom_range(99) < 3) begin
      now_ms -= $urandom_range(1, 5000);
    end else begin
      now_ms += $urandom_range(0, quiet_per / 2 + 64);
    end
    smp.ratio = RatioW'($urandom);
    smp.level = LevelW'($urandom);
    case (kind)
      KIND_STRONG: begin
        if ($urandom_range(1)) begin
          smp.ratio = RatioW'($urandom_range(trig, RatioMaxVal));
        end else begin
          smp.level = LevelW'($urandom_range(2, 255));
          smp.ratio = RatioW'($urandom_range((trig + 1) / 2, RatioMaxVal));
        end
      end
      KIND_WEAK: begin
        // With a zero trigger every sample is strong, so noise stands in.
        if (trig != 0) begin
          if ($urandom_range(1)) begin
            smp.level = LevelW'($urandom_range(0, 1));
            smp.ratio = RatioW'($urandom_range(0, trig - 1));
          end else begin
            smp.ratio = RatioW'($urandom_range(0, (trig - 1) / 2));
          end
        end
      end
      KIND_QUIET: begin
        smp.level = '0;
        smp.ratio = RatioW'($urandom_range(0, rel));
      end
      KIND_BUSY: begin
        if ($urandom_range(1) || rel == RatioMaxVal) begin
          smp.level = LevelW'($urandom_range(1, 255));
        end else begin
          smp.level = '0;
          smp.ratio = RatioW'($urandom_range(rel + 1, RatioMaxVal));
        end
      end
      default: begin
        if ($urandom_range(1)) begin
          now_ms = $urandom;
        end
      end
    endcase
    smp.time_ms = now_ms;
    return smp;
  endfunction

  // Called at a rising edge; returns at the edge where the word is taken.
  // A valid that stays high between words is never lowered in between.
  task automatic send_sample(input motion_sample_t smp);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({smp.time_ms, smp.level, smp.ratio});
    do @(posedge clk_i); while (!s_axis_tready);
    results_due.push_back(advance_detector(smp));
  endtask

  // Holds the sample stream off until every predicted result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_register(input reg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_TRIGGER_LEVEL:   trigger_lvl = data[RatioW-1:0];
      REG_RELEASE_LEVEL:   release_lvl = data[RatioW-1:0];
      REG_CONFIRM_COUNT:   confirm_cnt = data[RunW-1:0];
      REG_QUIET_PERIOD_MS: quiet_per   = data[PeriodW-1:0];
      default: ;
    endcase
  endtask

  // Bits above a register's width carry random junk that must be dropped.
  task automatic write_registers(input int unsigned trig, input int unsigned rel,
                                 input int unsigned conf, input int unsigned per);
    write_register(REG_TRIGGER_LEVEL, {2'($urandom), RatioW'(trig)});
    write_register(REG_RELEASE_LEVEL, {2'($urandom), RatioW'(rel)});
    write_register(REG_CONFIRM_COUNT, {12'($urandom), RunW'(conf)});
    write_register(REG_QUIET_PERIOD_MS, PeriodW'(per));
    cfg_valid_i <= 1'b0;
  endtask

  // Reset register values: half-trigger test, level one, confirm run and hold timer.
  task automatic test_reset_defaults();
    send_sample(motion_sample(0, 0, 0));
    send_sample(motion_sample(150, 2, 10));
    send_sample(motion_sample(149, 255, 20));
    send_sample(motion_sample(299, 1, 30));
    send_sample(motion_sample(300, 0, 40));
    send_sample(motion_sample(RatioMaxVal, 1, 50));
    send_sample(motion_sample(10000, 0, 60));
    send_sample(motion_sample(20, 0, 1000));
    send_sample(motion_sample(21, 0, 1500));
    send_sample(motion_sample(0, 0, 2000));
    send_sample(motion_sample(0, 0, 3999));
    send_sample(motion_sample(20, 0, 4000));
    drain_results();
  endtask

  // Quiet interval across the 32-bit wrap, then a step backward in time.
  task automatic test_time_wrap();
    sender_idle_pct = 30;
    sink_stall_pct  = 30;
    send_sample(motion_sample(10000, 0, 32'hFFFF_FF00));
    send_sample(motion_sample(10000, 0, 32'hFFFF_FF10));
    send_sample(motion_sample(10000, 0, 32'hFFFF_FF20));
    send_sample(motion_sample(0, 0, 32'hFFFF_FF30));
    send_sample(motion_sample(0, 0, 32'h0000_06FF));
    send_sample(motion_sample(0, 0, 32'h0000_0700));
    send_sample(motion_sample(300, 0, 5000));
    send_sample(motion_sample(300, 0, 5000));
    send_sample(motion_sample(300, 0, 5000));
    send_sample(motion_sample(0, 0, 5000));
    send_sample(motion_sample(0, 0, 4999));
    drain_results();
  endtask

  // Full-scale and zero thresholds, a zero confirm count and zero or minimal hold times.
  task automatic test_register_extremes();
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    write_registers(RatioMaxVal, RatioMaxVal, 0, 0);
    send_sample(motion_sample(0, 0, 0));
    send_sample(motion_sample(RatioMaxVal, 0, 1));
    send_sample(motion_sample(RatioMaxVal, 1, 2));
    send_sample(motion_sample(RatioMaxVal, 1, 3));
    send_sample(motion_sample(0, 0, 4));
    drain_results();
    write_registers(0, 0, 1, 1);
    send_sample(motion_sample(0, 0, 100));
    send_sample(motion_sample(0, 0, 100));
    send_sample(motion_sample(0, 0, 101));
    drain_results();
  endtask

  // Random phases; each one rotates the idling mix and loads a new register set.
  task automatic test_random_traffic();
    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      case (phase % 4)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 61; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 61; end
        default: begin sender_idle_pct = 20; sink_stall_pct = 20; end
      endcase
      case (phase)
        0: write_registers(TriggerReset, ReleaseReset, ConfirmReset, PeriodReset);
        1: write_registers(0, 0, 0, 0);
        2: write_registers(RatioMaxVal, RatioMaxVal, 15, 65535);
        default: write_registers($urandom_range(0, 10000), $urandom_range(0, 400),
                                 $urandom_range(1, 15), $urandom_range(0, 5000));
      endcase
      // Odd phases start just short of the time wrap.
      now_ms = phase[0] ? 32'hFFFF_FFFF - $urandom_range(0, 20000) : $urandom;
      repeat (WordsPerPhase) begin
        send_sample(draw_sample());
      end
      drain_results();
    end
  endtask

  // Every accepted result word is held against the oldest prediction.
  always @(posedge clk_i) begin
    motion_result_t due;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        note_fault($sformatf("result word %h with no sample pending", m_axis_tdata));
      end else begin
        due = results_due.pop_front();
        if (m_axis_tdata[0] !== due.active) begin
          note_fault($sformatf("motion_active expected %b got %b",
                               due.active, m_axis_tdata[0]));
        end
        if (m_axis_tdata[2:1] !== due.transition) begin
          note_fault($sformatf("transition expected %s got %b",
                               due.transition.name(), m_axis_tdata[2:1]));
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_time_wrap();
    test_register_extremes();
    test_random_traffic();
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mhd_pkg.sv
design/motion_hysteresis_detector.sv
design/mhd_checker.sv
dv/motion_hysteresis_detector_test.sv
